// File: design/sqrot_pkg.sv
// ----------------------------------------------------------------------------
// sqrot_pkg
// Shared types, constants and address helpers for the square matrix rotator.
// ----------------------------------------------------------------------------
package sqrot_pkg;

    localparam int MAX_DIM   = 8;
    localparam int CFG_W     = 4;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIMV_W    = $clog2(MAX_DIM + 1);
    localparam int CELLS     = MAX_DIM * MAX_DIM;
    localparam int ELEM_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RAM_DEPTH = 2 * CELLS;
    localparam int RAM_AW    = ELEM_W + 1;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

    // One completed matrix waiting to be drained.
    typedef struct packed {
        logic              bank;
        logic [DIMV_W-1:0] dim;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    // A dimension of zero behaves as one; anything above the maximum is clamped.
    function automatic logic [DIMV_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
        logic [DIMV_W-1:0] res;
        if (d == '0)
            res = DIMV_W'(1);
        else if (32'(d) > MAX_DIM)
            res = DIMV_W'(MAX_DIM);
        else
            res = DIMV_W'(d);
        return res;
    endfunction

    // Each bank holds one matrix with a fixed row stride of MAX_DIM.
    function automatic logic [RAM_AW-1:0] cell_addr(input logic bank,
                                                    input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        logic [ELEM_W-1:0] offs;
        offs = ELEM_W'(row) * ELEM_W'(MAX_DIM) + ELEM_W'(col);
        return {bank, offs};
    endfunction

endpackage

// File: design/sqrot_ram.sv
// ----------------------------------------------------------------------------
// sqrot_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sqrot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/sqrot_front.sv
// ----------------------------------------------------------------------------
// sqrot_front
// Accepts elements, writes them into the free bank and posts finished matrices.
// ----------------------------------------------------------------------------
module sqrot_front
    import sqrot_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [DATA_W-1:0] s_tdata,
    input  logic                     cfg_valid,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     q_full,
    output logic                     q_push,
    output q_entry_t                 q_push_entry,
    output logic                     wr_en,
    output logic [RAM_AW-1:0]        wr_addr,
    output logic [DATA_W-1:0]        wr_data
);

    logic [CFG_W-1:0]  dim_reg;
    logic [CFG_W-1:0]  dim_next;
    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  row_next;
    logic [IDX_W-1:0]  col_reg;
    logic [IDX_W-1:0]  col_next;
    logic              bank_reg;
    logic              bank_next;
    logic [DIMV_W-1:0] n;
    logic              last_col;
    logic              last_row;
    logic              accept;

    assign n        = eff_dim(dim_reg);
    assign last_col = (DIMV_W'(col_reg) == n - DIMV_W'(1));
    assign last_row = (DIMV_W'(row_reg) == n - DIMV_W'(1));

    // The queue holds at most the other bank while it is not full, so the
    // current bank is always free to write when ready is high.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign wr_en   = accept;
    assign wr_addr = cell_addr(bank_reg, row_reg, col_reg);
    assign wr_data = s_tdata;

    assign q_push             = accept && last_col && last_row;
    assign q_push_entry.bank  = bank_reg;
    assign q_push_entry.dim   = n;

    always_comb
    begin
        dim_next  = dim_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        bank_next = bank_reg;
        if (cfg_valid)
        begin
            dim_next = cfg_data;
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next  = '0;
                    bank_next = !bank_reg;
                end
                else
                begin
                    row_next = row_reg + IDX_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg  <= DIM_RESET;
            row_reg  <= '0;
            col_reg  <= '0;
            bank_reg <= 1'b0;
        end
        else
        begin
            dim_reg  <= dim_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            bank_reg <= bank_next;
        end
    end

endmodule

// File: design/sqrot_queue.sv
// ----------------------------------------------------------------------------
// sqrot_queue
// Two-entry queue of finished matrices between the loader and the drain side.
// ----------------------------------------------------------------------------
module sqrot_queue
    import sqrot_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output logic     full,
    output q_head_t  head
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/sqrot_back.sv
// ----------------------------------------------------------------------------
// sqrot_back
// Walks the rotated order of the queued matrix and streams it out.
// ----------------------------------------------------------------------------
module sqrot_back
    import sqrot_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  q_head_t                  head,
    output logic                     pop,
    output logic                     rd_en,
    output logic [RAM_AW-1:0]        rd_addr,
    input  logic [DATA_W-1:0]        rd_data,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] m_tdata,
    output logic                     m_tlast
);

    logic [IDX_W-1:0]  r_reg;
    logic [IDX_W-1:0]  r_next;
    logic [IDX_W-1:0]  c_reg;
    logic [IDX_W-1:0]  c_next;
    logic              vld_reg;
    logic              vld_next;
    logic              last_reg;
    logic              last_next;
    logic [DIMV_W-1:0] n;
    logic [IDX_W-1:0]  src_row;
    logic              last_c;
    logic              last_r;
    logic              advance;

    assign n       = head.entry.dim;
    assign last_c  = (DIMV_W'(c_reg) == n - DIMV_W'(1));
    assign last_r  = (DIMV_W'(r_reg) == n - DIMV_W'(1));
    // Output row r, column c comes from input row N-1-c, column r.
    assign src_row = IDX_W'(n - DIMV_W'(1) - DIMV_W'(c_reg));

    // The RAM read register doubles as the output data register; it only
    // loads when the output slot is empty or being taken.
    assign advance = !vld_reg || m_tready;
    assign rd_en   = advance && head.valid;
    assign rd_addr = cell_addr(head.entry.bank, src_row, r_reg);
    assign pop     = rd_en && last_c && last_r;

    assign m_tvalid = vld_reg;
    assign m_tdata  = rd_data;
    assign m_tlast  = last_reg;

    always_comb
    begin
        r_next    = r_reg;
        c_next    = c_reg;
        vld_next  = vld_reg;
        last_next = last_reg;
        if (advance)
        begin
            vld_next  = head.valid;
            last_next = last_c && last_r;
        end
        if (rd_en)
        begin
            if (last_c)
            begin
                c_next = '0;
                if (last_r)
                begin
                    r_next = '0;
                end
                else
                begin
                    r_next = r_reg + IDX_W'(1);
                end
            end
            else
            begin
                c_next = c_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg    <= '0;
            c_reg    <= '0;
            vld_reg  <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            r_reg    <= r_next;
            c_reg    <= c_next;
            vld_reg  <= vld_next;
            last_reg <= last_next;
        end
    end

endmodule

// File: design/square_matrix_rotate_clockwise.sv
// ----------------------------------------------------------------------------
// square_matrix_rotate_clockwise
// Loads an N by N matrix in row-major order and streams it out rotated
// 90 degrees clockwise, also in row-major order.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// s_*       in         tdata[31:0] = element
// m_*       out        tdata[31:0] = rotated_element, tlast = final_flag
// cfg_*     in         data[3:0]   = matrix_dim
//
// Loading and draining each move one element per cycle unless stalled; the drain
// side reads from the single registered read port of a two-bank RAM.
// The two banks let matrix k+1 load while matrix k drains, so sustained rate
// is about one element per cycle; input stalls only while both banks are full.
// Reset clears all counters and sets N to 8; the RAM needs no clearing.
// A configuration transfer restarts the load of the current matrix.
// ----------------------------------------------------------------------------
module square_matrix_rotate_clockwise
    import sqrot_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [DATA_W-1:0] s_tdata,   // [31:0] element
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] m_tdata,   // [31:0] rotated_element
    output logic                     m_tlast,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_data
);

    logic              q_full;
    logic              q_push;
    q_entry_t          q_push_entry;
    logic              q_pop;
    q_head_t           q_head;
    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    sqrot_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_push_entry (q_push_entry),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    sqrot_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head       (q_head)
    );

    sqrot_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sqrot_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .pop      (q_pop),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
